### src/rafc_pkg.sv
package rafc_pkg;

  // Field and datapath widths
  localparam int POS_W    = 24;             // Q16.8 coordinate
  localparam int CFG_W    = 24;             // configuration register width
  localparam int CFG_AW   = 2;              // register index width
  localparam int DIFF_W   = POS_W + 1;      // coordinate difference
  localparam int SQ_W     = 2 * DIFF_W;     // full squared length
  localparam int D2_W     = 2 * CFG_W;      // squared length inside the field
  localparam int FRAC_W   = 16;             // falloff, Q0.16
  localparam int LEN_W    = 32;             // distance, Q.16
  localparam int UNIT_SH  = 24;             // pre-shift of |d| before the unit divide
  localparam int UNIT_W   = 17;             // unit component, up to 1.0 in Q.16
  localparam int T_W      = FRAC_W + UNIT_W;
  localparam int P_W      = T_W + CFG_W;
  localparam int MAG_SH   = 32;
  localparam int MAG_W    = P_W - MAG_SH;
  localparam int FORCE_W  = 32;

  localparam logic [SQ_W-1:0] ONE_UNIT_SQ = SQ_W'(65536);

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_PULL_RANGE    = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_PULL_STRENGTH = CFG_AW'(1);

  // Pipeline depth: front end, falloff divide, square root, unit divide,
  // two multiplies, output register
  localparam int FRONT_STAGES = 4;
  localparam int LATENCY = FRONT_STAGES + FRAC_W + LEN_W + UNIT_W + 3;

  typedef struct packed {
    logic              inr;
    logic              sx;
    logic              sy;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic [D2_W-1:0]   d2;
    logic [D2_W-1:0]   num;
  } front_t;

  typedef struct packed {
    logic              inr;
    logic              sx;
    logic              sy;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic [D2_W-1:0]   d2;
  } frac_side_t;

  typedef struct packed {
    logic              inr;
    logic              sx;
    logic              sy;
    logic [DIFF_W-1:0] ax;
    logic [DIFF_W-1:0] ay;
    logic [FRAC_W-1:0] f;
  } sqrt_side_t;

  typedef struct packed {
    logic              inr;
    logic              sx;
    logic [FRAC_W-1:0] f;
  } unit_side_t;

endpackage

### src/rafc_front.sv
module rafc_front import rafc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [POS_W-1:0]  mine_x,
  input  logic [POS_W-1:0]  mine_y,
  input  logic [POS_W-1:0]  body_x,
  input  logic [POS_W-1:0]  body_y,
  input  logic [D2_W-1:0]   r2,
  output logic              out_valid,
  output front_t            out
);

  // stage 1: differences
  logic                     v1;
  logic signed [DIFF_W-1:0] dx1;
  logic signed [DIFF_W-1:0] dy1;
  // stage 2: squares and magnitudes
  logic                     v2;
  logic signed [SQ_W-1:0]   sqx;
  logic signed [SQ_W-1:0]   sqy;
  logic [DIFF_W-1:0]        ax2;
  logic [DIFF_W-1:0]        ay2;
  logic                     sx2;
  logic                     sy2;
  // stage 3: squared length
  logic                     v3;
  logic [SQ_W-1:0]          d2_3;
  logic [DIFF_W-1:0]        ax3;
  logic [DIFF_W-1:0]        ay3;
  logic                     sx3;
  logic                     sy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dx1 <= {mine_x[POS_W-1], mine_x} - {body_x[POS_W-1], body_x};
    dy1 <= {mine_y[POS_W-1], mine_y} - {body_y[POS_W-1], body_y};

    sqx <= dx1 * dx1;
    sqy <= dy1 * dy1;
    ax2 <= dx1[DIFF_W-1] ? (~dx1 + 1'b1) : dx1;
    ay2 <= dy1[DIFF_W-1] ? (~dy1 + 1'b1) : dy1;
    sx2 <= dx1[DIFF_W-1];
    sy2 <= dy1[DIFF_W-1];

    d2_3 <= $unsigned(sqx) + $unsigned(sqy);
    ax3 <= ax2;
    ay3 <= ay2;
    sx3 <= sx2;
    sy3 <= sy2;

    // in field when one unit <= |d| < range
    out.inr <= (d2_3 < SQ_W'(r2)) && (d2_3 >= ONE_UNIT_SQ);
    out.sx  <= sx3;
    out.sy  <= sy3;
    out.ax  <= ax3;
    out.ay  <= ay3;
    out.d2  <= d2_3[D2_W-1:0];
    out.num <= r2 - d2_3[D2_W-1:0];
  end

endmodule

### src/rafc_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Quotient must fit in QW bits.
module rafc_div #(
  parameter int NW = 64,
  parameter int DW = 48,
  parameter int QW = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld [QW];
  logic [CW-1:0] rem [QW];
  logic [DW-1:0] dv  [QW];
  logic [QW-1:0] q   [QW];
  logic [SW-1:0] sd  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic          c_vld;
    logic [CW-1:0] c_rem;
    logic [DW-1:0] c_dv;
    logic [QW-1:0] c_q;
    logic [SW-1:0] c_sd;
    logic [CW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_in
      assign c_vld = in_valid;
      assign c_rem = CW'(num);
      assign c_dv  = den;
      assign c_q   = '0;
      assign c_sd  = side_in;
    end else begin : g_prev
      assign c_vld = vld[k-1];
      assign c_rem = rem[k-1];
      assign c_dv  = dv[k-1];
      assign c_q   = q[k-1];
      assign c_sd  = sd[k-1];
    end

    assign trial = CW'(c_dv) << B;
    assign ge    = c_rem >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? c_rem - trial : c_rem;
      dv[k]  <= c_dv;
      q[k]   <= ge ? (c_q | (QW'(1) << B)) : c_q;
      sd[k]  <= c_sd;
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = q[QW-1];
  assign side_out  = sd[QW-1];

endmodule

### src/rafc_sqrt.sv
// Pipelined integer square root, one root bit per stage, MSB first.
module rafc_sqrt #(
  parameter int RW = 32,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*RW-1:0] radicand,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  localparam int VW = 2 * RW;

  logic          vld [RW];
  logic [VW-1:0] rem [RW];
  logic [RW-1:0] rt  [RW];
  logic [SW-1:0] sd  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic          c_vld;
    logic [VW-1:0] c_rem;
    logic [RW-1:0] c_rt;
    logic [SW-1:0] c_sd;
    logic [VW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_in
      assign c_vld = in_valid;
      assign c_rem = radicand;
      assign c_rt  = '0;
      assign c_sd  = side_in;
    end else begin : g_prev
      assign c_vld = vld[k-1];
      assign c_rem = rem[k-1];
      assign c_rt  = rt[k-1];
      assign c_sd  = sd[k-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    assign trial = (VW'(c_rt) << (B + 1)) | (VW'(1) << (2 * B));
    assign ge    = c_rem >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? c_rem - trial : c_rem;
      rt[k]  <= ge ? (c_rt | (RW'(1) << B)) : c_rt;
      sd[k]  <= c_sd;
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt[RW-1];
  assign side_out  = sd[RW-1];

endmodule

### src/radial_attraction_force_core.sv
// Channel   Signals                                    Transfer
// --------  -----------------------------------------  ------------------------------
// in        start, busy, mine_x/y, body_x/y            start high at a rising edge
// result    done, force_x, force_y, in_range           done high for one cycle
// config    cfg_we, cfg_addr, cfg_wdata                cfg_we high at a rising edge
//
// One pair enters per cycle; busy is never raised.
// Each result follows its start transfer through the bit-per-stage
// chain: falloff divide (16), square root (32), unit divide (17).
// Synchronous active-high reset clears all valid bits and both registers.
// The result side cannot stall, so the pipeline advances every cycle.
module radial_attraction_force_core import rafc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [POS_W-1:0]    mine_x,
  input  logic [POS_W-1:0]    mine_y,
  input  logic [POS_W-1:0]    body_x,
  input  logic [POS_W-1:0]    body_y,
  output logic                done,
  output logic [FORCE_W-1:0]  force_x,
  output logic [FORCE_W-1:0]  force_y,
  output logic                in_range,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int SAT_W = FORCE_W + 1;

  // Configuration registers; r2 is the registered square of pull_range.
  logic [CFG_W-1:0] pull_range;
  logic [CFG_W-1:0] pull_strength;
  logic [D2_W-1:0]  r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pull_range    <= '0;
      pull_strength <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PULL_RANGE:    pull_range    <= cfg_wdata;
        REG_PULL_STRENGTH: pull_strength <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= pull_range * pull_range;
  end

  assign busy = 1'b0;

  // Front end: differences, squares, squared length, field test
  logic   fr_valid;
  front_t fr;

  rafc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .mine_x   (mine_x),
    .mine_y   (mine_y),
    .body_x   (body_x),
    .body_y   (body_y),
    .r2       (r2),
    .out_valid(fr_valid),
    .out      (fr)
  );

  // Falloff f = (r2 - d2) * 2^16 / r2
  frac_side_t        fs_in;
  frac_side_t        fs_out;
  logic              fs_valid;
  logic [FRAC_W-1:0] falloff;

  assign fs_in = '{inr: fr.inr, sx: fr.sx, sy: fr.sy, ax: fr.ax, ay: fr.ay, d2: fr.d2};

  rafc_div #(
    .NW(D2_W + FRAC_W),
    .DW(D2_W),
    .QW(FRAC_W),
    .SW($bits(frac_side_t))
  ) u_frac_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fr_valid),
    .num      ({fr.num, {FRAC_W{1'b0}}}),
    .den      (r2),
    .side_in  (fs_in),
    .out_valid(fs_valid),
    .quo      (falloff),
    .side_out (fs_out)
  );

  // Distance len = sqrt(d2 * 2^16), Q.16
  sqrt_side_t       ss_in;
  sqrt_side_t       ss_out;
  logic             ss_valid;
  logic [LEN_W-1:0] len;

  assign ss_in = '{inr: fs_out.inr, sx: fs_out.sx, sy: fs_out.sy,
                   ax: fs_out.ax, ay: fs_out.ay, f: falloff};

  rafc_sqrt #(
    .RW(LEN_W),
    .SW($bits(sqrt_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fs_valid),
    .radicand ({fs_out.d2, {(2 * LEN_W - D2_W){1'b0}}}),
    .side_in  (ss_in),
    .out_valid(ss_valid),
    .root     (len),
    .side_out (ss_out)
  );

  // Unit vector components u = |d| * 2^24 / len, both lanes in lockstep
  unit_side_t        ux_in;
  unit_side_t        ux_out;
  logic              ux_valid;
  logic              uy_valid;
  logic              sy_u;
  logic [UNIT_W-1:0] ux;
  logic [UNIT_W-1:0] uy;

  assign ux_in = '{inr: ss_out.inr, sx: ss_out.sx, f: ss_out.f};

  rafc_div #(
    .NW(DIFF_W + UNIT_SH),
    .DW(LEN_W),
    .QW(UNIT_W),
    .SW($bits(unit_side_t))
  ) u_unit_x (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ss_valid),
    .num      ({ss_out.ax, {UNIT_SH{1'b0}}}),
    .den      (len),
    .side_in  (ux_in),
    .out_valid(ux_valid),
    .quo      (ux),
    .side_out (ux_out)
  );

  rafc_div #(
    .NW(DIFF_W + UNIT_SH),
    .DW(LEN_W),
    .QW(UNIT_W),
    .SW(1)
  ) u_unit_y (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ss_valid),
    .num      ({ss_out.ay, {UNIT_SH{1'b0}}}),
    .den      (len),
    .side_in  (ss_out.sy),
    .out_valid(uy_valid),
    .quo      (uy),
    .side_out (sy_u)
  );

  // Multiply stage A: f * u
  logic           va;
  logic           inr_a;
  logic           sx_a;
  logic           sy_a;
  logic [T_W-1:0] tx;
  logic [T_W-1:0] ty;
  // Multiply stage B: (f * u) * strength
  logic           vb;
  logic           inr_b;
  logic           sx_b;
  logic           sy_b;
  logic [P_W-1:0] px;
  logic [P_W-1:0] py;

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      done     <= 1'b0;
      in_range <= 1'b0;
    end else begin
      va       <= ux_valid & uy_valid;
      vb       <= va;
      done     <= vb;
      in_range <= vb & inr_b;
    end
  end

  // Saturate a magnitude to the signed result range and apply the sign
  function automatic logic [FORCE_W-1:0] sat_apply(input logic [MAG_W-1:0] mag,
                                                   input logic neg);
    logic [SAT_W-1:0] m;
    logic [SAT_W-1:0] lim;
    m   = SAT_W'(mag);
    lim = SAT_W'(1) << (FORCE_W - 1);
    if (!neg) begin
      lim = lim - 1'b1;
    end
    if (m > lim) begin
      m = lim;
    end
    return neg ? FORCE_W'(~m + 1'b1) : FORCE_W'(m);
  endfunction

  always_ff @(posedge clk) begin
    tx    <= ux_out.f * ux;
    ty    <= ux_out.f * uy;
    inr_a <= ux_out.inr;
    sx_a  <= ux_out.sx;
    sy_a  <= sy_u;

    px    <= tx * pull_strength;
    py    <= ty * pull_strength;
    inr_b <= inr_a;
    sx_b  <= sx_a;
    sy_b  <= sy_a;

    force_x <= inr_b ? sat_apply(px[P_W-1:MAG_SH], sx_b) : '0;
    force_y <= inr_b ? sat_apply(py[P_W-1:MAG_SH], sy_b) : '0;
  end

endmodule

### src/rafc_checker.sv
module rafc_checker import rafc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               in_range,
  input logic [FORCE_W-1:0] force_x,
  input logic [FORCE_W-1:0] force_y
);

  // every result traces back to an accepted start transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start & ~busy, LATENCY))
    else $error("result without matching start");

  // no stale result right after reset
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  // out-of-field results carry zero force
  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (force_x == '0 && force_y == '0))
    else $error("nonzero force outside field");

  // in_range is only shown with a result
  a_range_strobe: assert property (@(posedge clk) disable iff (rst)
    !done |-> !in_range)
    else $error("in_range without result");

endmodule

bind radial_attraction_force_core rafc_checker u_rafc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .in_range(in_range),
  .force_x (force_x),
  .force_y (force_y)
);
